// ===== hw/rtl/b2da_pkg.sv =====
// ============================================================================
// b2da_pkg
// Shared types, constants and functions of the binary to decimal ASCII unit.
// ============================================================================
`default_nettype none

package b2da_pkg;

    localparam int NUMBER_WIDTH = 16;
    localparam int IN_TDATA_W   = ((NUMBER_WIDTH + 7) / 8) * 8;

    // 99999 needs 17 bits
    localparam int VAL_W        = 17;
    localparam int EXT_W        = (NUMBER_WIDTH > VAL_W) ? NUMBER_WIDTH : VAL_W;
    localparam logic [VAL_W-1:0] SAT_VALUE = VAL_W'(99999);

    localparam int MAX_DIGITS   = 5;
    localparam int POS_W        = 3;

    localparam int CHAR_W       = 6;
    localparam int OUT_TDATA_W  = ((CHAR_W + 7) / 8) * 8;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] top;    // position of the leading digit
    } t_item;

    function automatic logic [VAL_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [VAL_W-1:0] r;
        unique case (pos)
            3'd0:    r = VAL_W'(1);
            3'd1:    r = VAL_W'(10);
            3'd2:    r = VAL_W'(100);
            3'd3:    r = VAL_W'(1000);
            3'd4:    r = VAL_W'(10000);
            3'd5:    r = VAL_W'(100000);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/binary_to_decimal_ascii_unit.sv =====
// ============================================================================
// binary_to_decimal_ascii_unit
// Unsigned binary number to decimal ASCII digit stream.
// ============================================================================
// Each accepted number (above 99999 saturated) leaves as its decimal digits,
// ASCII '0'..'9', most significant first without leading zeros, tlast on the
// final digit; zero gives a single '0'. The digit unit produces one character
// per cycle while the output is not stalled, for 1 to 5 digits per number. A
// two-entry queue behind the input lets up to two classified numbers wait
// while digits drain, and the output register holds a character under stall.
`default_nettype none

module binary_to_decimal_ascii_unit
    import b2da_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // [15:0] number
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // [5:0] digit_char
    output logic                        o_m_tlast    // last_digit
);

    logic  q_full, q_push, q_valid, q_pop;
    t_item q_in, q_out;

    b2da_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (q_in)
    );

    b2da_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    b2da_digit u_digit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_out),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/b2da_front.sv =====
// ============================================================================
// b2da_front
// Accepts numbers, saturates them to five digits and finds the leading digit.
// ============================================================================
`default_nettype none

module b2da_front
    import b2da_pkg::*;
(
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_TDATA_W-1:0] i_s_tdata,   // [NUMBER_WIDTH-1:0] number
    input  wire logic                  i_q_full,
    output logic                       o_q_push,
    output t_item                      o_q_item
);

    logic [EXT_W-1:0] ext;
    logic [VAL_W-1:0] sat;

    assign ext = EXT_W'(i_s_tdata[NUMBER_WIDTH-1:0]);

    always_comb begin
        if (ext > EXT_W'(SAT_VALUE)) begin
            sat = SAT_VALUE;
        end else begin
            sat = VAL_W'(ext);
        end
    end

    always_comb begin
        o_q_item.value = sat;
        if (sat >= pow10(POS_W'(4))) begin
            o_q_item.top = POS_W'(4);
        end else if (sat >= pow10(POS_W'(3))) begin
            o_q_item.top = POS_W'(3);
        end else if (sat >= pow10(POS_W'(2))) begin
            o_q_item.top = POS_W'(2);
        end else if (sat >= pow10(POS_W'(1))) begin
            o_q_item.top = POS_W'(1);
        end else begin
            o_q_item.top = POS_W'(0);
        end
    end

    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && !i_q_full;

endmodule

`default_nettype wire

// ===== hw/rtl/b2da_fifo.sv =====
// ============================================================================
// b2da_fifo
// Two-entry queue between the front classifier and the digit unit.
// ============================================================================
`default_nettype none

module b2da_fifo
    import b2da_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_item     i_item,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_item     o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt,  n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = do_pop  ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == QCNT_W'(QDEPTH)) |-> (r_wptr == r_rptr))
        else $error("queue pointers out of step with count");

endmodule

`default_nettype wire

// ===== hw/rtl/b2da_digit.sv =====
// ============================================================================
// b2da_digit
// Peels one decimal digit per cycle when not stalled, leading digit first, into an output reg.
// ============================================================================
`default_nettype none

module b2da_digit
    import b2da_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  t_item                       i_q_item,
    output logic                        o_q_pop,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // [5:0] digit_char
    output logic                        o_m_tlast    // last_digit
);

    logic [VAL_W-1:0]  r_val, n_val;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_busy, n_busy;
    logic              r_ovalid, n_ovalid;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;

    logic [VAL_W-1:0]  base, thr, sub_amt;
    logic [3:0]        digit;
    logic              advance, load;

    // digit = largest d with d * 10^pos <= value
    always_comb begin
        base    = pow10(r_pos);
        digit   = '0;
        sub_amt = '0;
        thr     = '0;
        for (int d = 1; d <= 9; d++) begin
            thr = VAL_W'(base * VAL_W'(d));
            if (r_val >= thr) begin
                digit   = 4'(d);
                sub_amt = thr;
            end
        end
    end

    assign advance = r_busy && (!r_ovalid || i_m_tready);
    assign load    = i_q_valid && (!r_busy || (advance && r_pos == '0));
    assign o_q_pop = load;

    always_comb begin
        n_val    = r_val;
        n_pos    = r_pos;
        n_busy   = r_busy;
        n_ovalid = r_ovalid && !i_m_tready;
        n_char   = r_char;
        n_last   = r_last;
        if (advance) begin
            n_ovalid = 1'b1;
            n_char   = ASCII_ZERO + CHAR_W'(digit);
            n_last   = (r_pos == '0);
            n_val    = r_val - sub_amt;
            n_pos    = r_pos - 1'b1;
            if (r_pos == '0) begin
                n_busy = 1'b0;
            end
        end
        if (load) begin
            n_val  = i_q_item.value;
            n_pos  = i_q_item.top;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_pos  <= n_pos;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OUT_TDATA_W'(r_char);
    assign o_m_tlast  = r_last;

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_char >= ASCII_ZERO && r_char <= ASCII_NINE))
        else $error("digit character out of range");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos < POS_W'(MAX_DIGITS) && r_val < pow10(r_pos + 1'b1)))
        else $error("remainder exceeds current digit position");

endmodule

`default_nettype wire

// ===== verif/b2da_checker.sv =====
// ============================================================================
// b2da_checker
// Digit stream checker for the binary to decimal ASCII unit.
// ============================================================================
// Watches both stream channels. Every number accepted on the slave side is
// expanded into its expected ASCII digit beats, most significant first, with
// the last beat marked. Every digit beat accepted on the master side is
// compared field by field with the oldest pending beat. Failures are counted
// and the number of beats still due is handed to the testbench top.
`default_nettype none

module b2da_checker
    import b2da_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // [15:0] number
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,   // [5:0] digit_char
    input  wire logic                   i_m_tlast,   // last_digit
    output int unsigned                 o_fail_count,
    output int unsigned                 o_digits_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DIGIT_CAP = 99999;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } t_digit_beat;

    t_digit_beat digits_due[$];
    int unsigned fail_count     = 0;
    int unsigned digits_pending = 0;

    assign o_fail_count     = fail_count;
    assign o_digits_pending = digits_pending;

    function automatic void expand_digits(input logic [IN_TDATA_W-1:0] word);
        logic [NUMBER_WIDTH-1:0] number;
        int unsigned             value;
        logic [3:0]              decimals[$];
        t_digit_beat             beat;
        number = word[NUMBER_WIDTH-1:0];
        value  = number;
        if (value > DIGIT_CAP) begin
            value = DIGIT_CAP;
        end
        do begin
            decimals.push_front(4'(value % 10));
            value = value / 10;
        end while (value != 0 && decimals.size() < MAX_DIGITS);
        foreach (decimals[k]) begin
            beat.digit_char = ASCII_ZERO + CHAR_W'(decimals[k]);
            beat.last_digit = (k == decimals.size() - 1);
            digits_due.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        t_digit_beat want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                expand_digits(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (digits_due.size() == 0) begin
                    $error("unexpected beat: digit_char %0d, last_digit %0b",
                           i_m_tdata[CHAR_W-1:0], i_m_tlast);
                    fail_count++;
                end else begin
                    want = digits_due.pop_front();
                    if (i_m_tdata[CHAR_W-1:0] !== want.digit_char) begin
                        $error("digit_char: expected %0d, actual %0d",
                               want.digit_char, i_m_tdata[CHAR_W-1:0]);
                        fail_count++;
                    end
                    if (i_m_tlast !== want.last_digit) begin
                        $error("last_digit: expected %0b, actual %0b",
                               want.last_digit, i_m_tlast);
                        fail_count++;
                    end
                end
            end
            digits_pending = digits_due.size();
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ============================================================================
// tb
// Testbench top for the binary to decimal ASCII unit.
// ============================================================================
// Feeds directed numbers (zero, digit-count boundaries, full scale, bit
// patterns) and then random numbers weighted over every digit count, in
// bursts with random gaps. The receiver stalls on its own pattern, including
// one long hold-off that backs the unit up into its input. The checker beside
// the unit predicts and compares every digit beat; this top gives the verdict.
`default_nettype none

module tb
    import b2da_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 420;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned HOLD_START   = 400;
    localparam int unsigned LONG_HOLD    = 150;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef enum int unsigned {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // [15:0] number
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // [5:0] digit_char
    logic                   o_m_tlast;   // last_digit

    int unsigned fail_count;
    int unsigned digits_pending;
    int unsigned cycle_count = 0;

    binary_to_decimal_ascii_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    b2da_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_m_tlast        (o_m_tlast),
        .o_fail_count     (fail_count),
        .o_digits_pending (digits_pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL binary_to_decimal_ascii_unit");
        $finish;
    end

    function automatic logic [IN_TDATA_W-1:0] pick_number();
        int unsigned value;
        int unsigned scale;
        case ($urandom_range(0, 7))
            0: value = $urandom_range(0, 9);
            1: value = $urandom_range(10, 99);
            2: value = $urandom_range(100, 999);
            3: value = $urandom_range(1000, 9999);
            4: value = $urandom_range(10000, 65535);
            5: value = $urandom;
            6: begin
                scale = 1;
                repeat ($urandom_range(0, 4)) scale = scale * 10;
                value = scale + $urandom_range(0, 2) - 1;
            end
            default: begin
                // sparse digits: interior zeros
                value = $urandom_range(1, 6) * 10000 + $urandom_range(0, 9) * 100
                        + $urandom_range(0, 1) * $urandom_range(0, 9);
            end
        endcase
        return IN_TDATA_W'(value);
    endfunction

    task automatic offer_number(input logic [IN_TDATA_W-1:0] number,
                                inout int unsigned burst_left);
        int unsigned gap;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= number;
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= IN_TDATA_W'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // receiver
    initial begin
        t_rx_mode    mode;
        int unsigned run;
        int unsigned k;
        int unsigned period_on;
        int unsigned period_off;
        bit          held_off;
        i_m_tready = 1'b0;
        held_off   = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held_off && cycle_count >= HOLD_START) begin
                held_off = 1'b1;
                for (k = 0; k < LONG_HOLD; k++) begin
                    @(negedge i_clk);
                    i_m_tready <= 1'b0;
                end
            end
            mode       = t_rx_mode'($urandom_range(0, 4));
            run        = $urandom_range(10, 60);
            period_on  = $urandom_range(1, 4);
            period_off = $urandom_range(1, 4);
            for (k = 0; k < run; k++) begin
                @(negedge i_clk);
                case (mode)
                    RX_ALWAYS:   i_m_tready <= 1'b1;
                    RX_COIN:     i_m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:   i_m_tready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_m_tready <= ((k % (period_on + period_off)) < period_on);
                    default:     i_m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // sender and verdict
    initial begin
        logic [IN_TDATA_W-1:0] directed[$];
        int unsigned           burst_left;
        int unsigned           n;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        directed = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd99, 16'd100, 16'd101,
                     16'd999, 16'd1000, 16'd9999, 16'd10000, 16'd10001, 16'd12345,
                     16'd54321, 16'd60006, 16'd65534, 16'd65535, 16'h8000, 16'h5555,
                     16'hAAAA, 16'h00FF, 16'hFF00, 16'd0};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        burst_left = $urandom_range(1, 8);
        foreach (directed[k]) begin
            offer_number(directed[k], burst_left);
        end
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            offer_number(pick_number(), burst_left);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        while (digits_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && digits_pending == 0) begin
            $display("PASS binary_to_decimal_ascii_unit");
        end else begin
            $display("FAIL binary_to_decimal_ascii_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
